// ===== rtl/mexp_pkg.sv =====
package mexp_pkg;

    localparam int MODULUS_RESET = 55;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_REDUCE = 5'b00010,
        ST_MULT   = 5'b00100,
        ST_SQUARE = 5'b01000,
        ST_FINISH = 5'b10000
    } mexp_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mexp_mul_stat_t;

endpackage

// ===== rtl/mexp_mulser.sv =====
module mexp_mulser #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [OPERAND_WIDTH-1:0]   x,
    input  logic [OPERAND_WIDTH-1:0]   y,
    input  logic [OPERAND_WIDTH:0]     modulus,
    output logic [OPERAND_WIDTH-1:0]   result,
    output mexp_pkg::mexp_mul_stat_t   stat
);

    localparam int CNT_W = $clog2(OPERAND_WIDTH);

    logic [OPERAND_WIDTH-1:0] r_reg, r_next;
    logic [OPERAND_WIDTH-1:0] x_reg, x_next;
    logic [OPERAND_WIDTH-1:0] y_reg, y_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;

    logic [OPERAND_WIDTH:0]   dbl;
    logic [OPERAND_WIDTH-1:0] dbl_red;
    logic [OPERAND_WIDTH:0]   sum;
    logic [OPERAND_WIDTH-1:0] sum_red;

    // double, reduce, add the selected multiplicand, reduce
    always_comb
    begin
        dbl = {r_reg, 1'b0};
        if (dbl >= modulus)
        begin
            dbl_red = OPERAND_WIDTH'(dbl - modulus);
        end
        else
        begin
            dbl_red = dbl[OPERAND_WIDTH-1:0];
        end
        sum = {1'b0, dbl_red} + (y_reg[OPERAND_WIDTH-1] ? {1'b0, x_reg} : '0);
        if (sum >= modulus)
        begin
            sum_red = OPERAND_WIDTH'(sum - modulus);
        end
        else
        begin
            sum_red = sum[OPERAND_WIDTH-1:0];
        end
    end

    always_comb
    begin
        r_next    = r_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            r_next    = '0;
            x_next    = x;
            y_next    = y;
            cnt_next  = CNT_W'(OPERAND_WIDTH - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            r_next   = sum_red;
            y_next   = {y_reg[OPERAND_WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        x_reg <= x_next;
        y_reg <= y_next;
    end

    assign result    = r_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("multiply started while busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg) && !busy_reg)
        else $error("done without a running multiply");

    a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ({1'b0, r_reg} < modulus))
        else $error("product not reduced");

endmodule

// ===== rtl/modular_exponentiation.sv =====
// Per item: one base reduction plus one modular multiply per set exponent bit and one
// squaring per exponent bit below the highest set bit; each multiply runs in the
// bit-serial multiplier. Items are taken one at a time; a new item is taken once the
// last one is finished, also while the last result still waits to be taken.
// Reset: asynchronous, active low; modulus returns to 55, channels go empty.
module modular_exponentiation #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [OPERAND_WIDTH-1:0] base_value,
    input  logic [OPERAND_WIDTH-1:0] exponent_value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [OPERAND_WIDTH-1:0] power_result,
    input  logic                     modulus_we,
    input  logic [OPERAND_WIDTH-1:0] modulus_data
);

    mexp_pkg::mexp_state_t state_reg, state_next;

    logic [OPERAND_WIDTH-1:0] modulus_reg;
    logic [OPERAND_WIDTH-1:0] sq_reg, sq_next;
    logic [OPERAND_WIDTH-1:0] acc_reg, acc_next;
    logic [OPERAND_WIDTH-1:0] ex_reg, ex_next;
    logic [OPERAND_WIDTH-1:0] out_reg, out_next;
    logic                     out_valid_reg, out_valid_next;

    logic [OPERAND_WIDTH:0]   mod_eff;
    logic [OPERAND_WIDTH-1:0] one_red;
    logic [OPERAND_WIDTH-1:0] dec_rem;
    logic                     mul_start;
    logic [OPERAND_WIDTH-1:0] mul_x;
    logic [OPERAND_WIDTH-1:0] mul_y;
    logic [OPERAND_WIDTH-1:0] mul_result;
    mexp_pkg::mexp_mul_stat_t mul_stat;

    // a zero modulus reduces by 2^OPERAND_WIDTH
    assign mod_eff = (modulus_reg == '0) ? {1'b1, {OPERAND_WIDTH{1'b0}}}
                                         : {1'b0, modulus_reg};
    assign one_red = (modulus_reg == OPERAND_WIDTH'(1)) ? '0 : OPERAND_WIDTH'(1);
    assign dec_rem = (state_reg == mexp_pkg::ST_SQUARE) ? (ex_reg >> 1) : ex_reg;

    mexp_mulser #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .x       (mul_x),
        .y       (mul_y),
        .modulus (mod_eff),
        .result  (mul_result),
        .stat    (mul_stat)
    );

    always_comb
    begin
        state_next     = state_reg;
        sq_next        = sq_reg;
        acc_next       = acc_reg;
        ex_next        = ex_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        mul_start      = 1'b0;
        mul_x          = sq_reg;
        mul_y          = sq_reg;
        case (state_reg)
            mexp_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    ex_next    = exponent_value;
                    acc_next   = OPERAND_WIDTH'(1);
                    mul_start  = 1'b1;
                    mul_x      = one_red;
                    mul_y      = base_value;
                    state_next = mexp_pkg::ST_REDUCE;
                end
            end
            mexp_pkg::ST_REDUCE, mexp_pkg::ST_SQUARE:
            begin
                if (mul_stat.done)
                begin
                    sq_next = mul_result;
                    ex_next = dec_rem;
                    if (dec_rem == '0)
                    begin
                        state_next = mexp_pkg::ST_FINISH;
                    end
                    else if (dec_rem[0])
                    begin
                        mul_start  = 1'b1;
                        mul_x      = mul_result;
                        mul_y      = acc_reg;
                        state_next = mexp_pkg::ST_MULT;
                    end
                    else
                    begin
                        mul_start  = 1'b1;
                        mul_x      = mul_result;
                        mul_y      = mul_result;
                        state_next = mexp_pkg::ST_SQUARE;
                    end
                end
            end
            mexp_pkg::ST_MULT:
            begin
                if (mul_stat.done)
                begin
                    acc_next = mul_result;
                    if (ex_reg[OPERAND_WIDTH-1:1] == '0)
                    begin
                        state_next = mexp_pkg::ST_FINISH;
                    end
                    else
                    begin
                        mul_start  = 1'b1;
                        state_next = mexp_pkg::ST_SQUARE;
                    end
                end
            end
            mexp_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next       = acc_reg;
                    out_valid_next = 1'b1;
                    state_next     = mexp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mexp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mexp_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            modulus_reg   <= OPERAND_WIDTH'(mexp_pkg::MODULUS_RESET);
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (modulus_we)
            begin
                modulus_reg <= modulus_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg  <= sq_next;
        acc_reg <= acc_next;
        ex_reg  <= ex_next;
        out_reg <= out_next;
    end

    assign in_ready     = (state_reg == mexp_pkg::ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign power_result = out_reg;

    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        mul_start |-> !mul_stat.busy)
        else $error("multiply launched while busy");

    a_accept_to_reduce: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == mexp_pkg::ST_REDUCE) && mul_stat.busy)
        else $error("accepted item did not start base reduction");

    a_wait_has_mul: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == mexp_pkg::ST_REDUCE) || (state_reg == mexp_pkg::ST_MULT)
            || (state_reg == mexp_pkg::ST_SQUARE)) |-> (mul_stat.busy || mul_stat.done))
        else $error("waiting on a multiply that is not running");

    a_square_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mexp_pkg::ST_MULT) |-> ({1'b0, sq_reg} < mod_eff))
        else $error("running square not reduced");

endmodule
